// ----- src/rrc_pkg.sv -----
// Shared types, widths and the Q1.17 tap table for the 61-tap RRC filter.
// No dependencies; imported by every module of the block.
package rrc_pkg;

	localparam int SampleW  = 16;
	localparam int CoefW    = 18;
	// sum of |taps| < 2^18, times 2^15 stays below 2^33
	localparam int AccW     = 34;
	localparam int FracBits = 17;
	localparam int NumTaps  = 61;
	localparam int HalfTaps = 31;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0]   coef_t;
	typedef logic signed [AccW-1:0]    acc_t;

	// first half of the symmetric taps, last entry is the center tap
	localparam int RrcHalf [HalfTaps] = '{
		  -148,   -469,   -756,   -949,   -996,   -864,   -547,    -77,
		   486,   1051,   1514,   1772,   1743,   1382,    699,   -241,
		 -1314,  -2352,  -3159,  -3542,  -3336,  -2434,   -803,   1496,
		  4317,   7432,  10563,  13408,  15682,  17150,  17657
	};

	function automatic coef_t tap_coef(input int t);
		int k;
		k = (t <= HalfTaps - 1) ? t : (NumTaps - 1 - t);
		return coef_t'(RrcHalf[k]);
	endfunction

endpackage

// ----- src/rrc_tap_cell.sv -----
// One cell of the transposed-form FIR chain: multiply-accumulate into a partial sum.
// Depends on rrc_pkg.
module rrc_tap_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rrc_pkg::sample_t x,
	input  rrc_pkg::coef_t   coef,
	input  rrc_pkg::acc_t    sum_in,
	output rrc_pkg::acc_t    sum_q
);
	import rrc_pkg::*;

	logic signed [SampleW+CoefW-1:0] prod;

	assign prod = coef * x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_in + acc_t'(prod);
		end
	end

endmodule

// ----- src/rrc_out_stage.sv -----
// Output pipeline: registers the full sum, then truncates toward zero,
// saturates to 16 bits and holds the beat for the master side. Depends on rrc_pkg.
module rrc_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rrc_pkg::acc_t    acc_in,
	output logic             m_tvalid,
	input  logic             m_tready,
	output rrc_pkg::sample_t m_tdata   // [15:0] sample_out
);
	import rrc_pkg::*;

	localparam int QW = AccW - FracBits;

	logic             v_s1;
	acc_t             acc_s1;
	logic             adv;
	logic             load;
	acc_t             biased;
	logic [QW-1:0]    qsh;
	logic             ovf;
	sample_t          sat;
	logic             out_valid_s2;
	sample_t          out_data_s2;

	assign adv      = !out_valid_s2 || m_tready;
	assign in_ready = !v_s1 || adv;
	assign load     = in_valid && in_ready;

	// bias negatives so the arithmetic shift truncates toward zero
	assign biased = acc_s1[AccW-1] ? acc_s1 + acc_t'((1 << FracBits) - 1) : acc_s1;
	assign qsh    = biased[AccW-1:FracBits];
	assign ovf    = (qsh[QW-1:SampleW-1] != '0) && (qsh[QW-1:SampleW-1] != '1);

	always_comb begin
		if (ovf) begin
			sat = qsh[QW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
		end else begin
			sat = sample_t'(qsh[SampleW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_s1 <= acc_in;
		end
		if (adv && v_s1) begin
			out_data_s2 <= sat;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;

`ifndef SYNTHESIS
	a_load_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> v_s1)
		else $error("accepted beat did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv && !load |=> v_s1 && $stable(acc_s1))
		else $error("stalled stage 1 lost or changed its sum");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv |=> m_tvalid)
		else $error("stage 1 moved on but no output beat appeared");
`endif

endmodule

// ----- src/rrc_fir_61_tap.sv -----
// 61-tap root-raised-cosine FIR, transposed form: 60 tap cells plus an output stage.
// An input beat is registered in stage 1, then in the output register. Throughput: one beat
// per cycle unless m_tready stalls the output; each tap cell does one multiply-accumulate per beat.
// Input beats are taken while stage 1 is free even if the output beat is stalled.
// Reset (arst_n low, asynchronous) zeroes every partial sum and empties the pipeline.
// Depends on rrc_pkg, rrc_tap_cell, rrc_out_stage.
module rrc_fir_61_tap (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  rrc_pkg::sample_t s_tdata,   // [15:0] sample_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output rrc_pkg::sample_t m_tdata    // [15:0] sample_out
);
	import rrc_pkg::*;

	localparam coef_t HeadCoef = tap_coef(0);

	acc_t                            part [1:NumTaps];
	logic                            in_acc;
	logic signed [SampleW+CoefW-1:0] head_prod;
	acc_t                            head_sum;

	assign in_acc        = s_tvalid && s_tready;
	assign part[NumTaps] = '0;

	for (genvar k = 1; k < NumTaps; k++) begin : g_cell
		rrc_tap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (in_acc),
			.x      (s_tdata),
			.coef   (tap_coef(k)),
			.sum_in (part[k+1]),
			.sum_q  (part[k])
		);
	end

	assign head_prod = HeadCoef * s_tdata;
	assign head_sum  = acc_t'(head_prod) + part[1];

	rrc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.acc_in   (head_sum),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- dv/rrc_fir_checker.sv -----
`timescale 1ns / 100ps
// Checker for the 61-tap RRC FIR: predicts every filtered sample from the input beats
// and compares it with the output beats. Depends on rrc_pkg for the sample type.
module rrc_fir_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  rrc_pkg::sample_t s_tdata,    // [15:0] sample_in
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  rrc_pkg::sample_t m_tdata,    // [15:0] sample_out
	output int               mismatches,
	output int               pending,
	output int               beats_in,
	output int               beats_out,
	output int               full_scale_outs
);
	import rrc_pkg::*;

	localparam int HistDepth = 60;

	// taps 0..30 in Q1.17, tap 30 is the center; taps 31..60 mirror them
	localparam int HalfTapsQ17 [31] = '{
		  -148,   -469,   -756,   -949,   -996,   -864,   -547,    -77,
		   486,   1051,   1514,   1772,   1743,   1382,    699,   -241,
		 -1314,  -2352,  -3159,  -3542,  -3336,  -2434,   -803,   1496,
		  4317,   7432,  10563,  13408,  15682,  17150,  17657
	};

	sample_t past_samples [HistDepth];   // newest first
	sample_t expected_out [$];

	function automatic sample_t filter_sample(input sample_t x);
		longint acc;
		longint q;
		int     k;
		acc = longint'(HalfTapsQ17[0]) * x;
		for (int t = 1; t <= HistDepth; t++) begin
			k = (t <= 30) ? t : HistDepth - t;
			acc += longint'(HalfTapsQ17[k]) * past_samples[t-1];
		end
		for (int t = HistDepth - 1; t > 0; t--)
			past_samples[t] = past_samples[t-1];
		past_samples[0] = x;
		// drop fraction toward zero, not toward minus infinity
		q = (acc < 0) ? -((-acc) >>> 17) : (acc >>> 17);
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return sample_t'(q);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sample_t want;
		if (!arst_n) begin
			foreach (past_samples[i])
				past_samples[i] = '0;
			expected_out.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				if (expected_out.size() == 0) begin
					$error("sample_out beat with nothing expected: actual %0d", m_tdata);
					mismatches++;
				end else begin
					want = expected_out.pop_front();
					if (m_tdata !== want) begin
						$error("sample_out mismatch: expected %0d, actual %0d", want, m_tdata);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				beats_in++;
				want = filter_sample(s_tdata);
				if (want == 16'sh7fff || want == 16'sh8000)
					full_scale_outs++;
				expected_out.push_back(want);
			end
			pending <= expected_out.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for the 61-tap RRC FIR: clock, reset, stream stimulus and verdict.
// Depends on rrc_pkg, rrc_fir_61_tap and rrc_fir_checker.
module tb_top;
	import rrc_pkg::*;

	localparam sample_t DirectedSamples [22] = '{
		16'sh7fff, 16'sh8000, 0, 1, -1, 2, -2, 16384, -16384, 16'sh5555, 16'shaaaa,
		16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
		0, 0, 0, 255, -256
	};

	logic    clk      = 1'b0;
	logic    arst_n   = 1'b0;
	logic    s_tvalid = 1'b0;
	logic    s_tready;
	sample_t s_tdata  = '0;
	logic    m_tvalid;
	logic    m_tready = 1'b0;
	sample_t m_tdata;

	int tx_idle_pct = 31;
	int rx_idle_pct = 54;
	int squeeze_req = 0;
	int sent        = 0;

	int mismatches;
	int pending;
	int beats_in;
	int beats_out;
	int full_scale_outs;

	rrc_fir_61_tap u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rrc_fir_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.pending         (pending),
		.beats_in        (beats_in),
		.beats_out       (beats_out),
		.full_scale_outs (full_scale_outs)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_sample(input sample_t v);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drive_signal_mix(input int n_items);
		int      stop_at;
		int      kind;
		int      len;
		int      k;
		bit      flip;
		bit      neg_tap;
		sample_t v;
		stop_at = sent + n_items;
		while (sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				len = $urandom_range(1, 40);
				repeat (len)
					send_sample(sample_t'($urandom));
			end else if (kind < 55) begin
				// sign-matched to the taps so the sum lands past full scale;
				// a quarter of the bursts are cut short
				flip = $urandom_range(1);
				len = ($urandom_range(3) == 0) ? $urandom_range(10, 60) : 61;
				for (int age = 60; age > 60 - len; age--) begin
					k = (age <= 30) ? age : 60 - age;
					neg_tap = (k <= 7) || (k >= 15 && k <= 22);
					if (neg_tap ^ flip)
						v = sample_t'(-int'($urandom_range(24000, 32768)));
					else
						v = sample_t'($urandom_range(24000, 32767));
					send_sample(v);
				end
			end else if (kind < 72) begin
				// impulse then silence: walks the response tap by tap
				case ($urandom_range(4))
					0: v = 16'sh7fff;
					1: v = 16'sh8000;
					2: v = 1;
					3: v = -1;
					default: v = sample_t'($urandom);
				endcase
				send_sample(v);
				len = $urandom_range(0, 65);
				repeat (len)
					send_sample('0);
			end else if (kind < 88) begin
				// tiny values: negative sums must truncate toward zero
				len = $urandom_range(1, 30);
				repeat (len)
					send_sample(sample_t'(int'($urandom_range(8)) - 4));
			end else begin
				len = $urandom_range(1, 40);
				repeat (len)
					send_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
			end
		end
	endtask

	// output side; each bump of squeeze_req starts one long hold-off
	initial begin : receiver
		int hold;
		int seen_req;
		hold = 0;
		seen_req = 0;
		forever begin
			@(posedge clk);
			if (squeeze_req != seen_req) begin
				seen_req = squeeze_req;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DirectedSamples[i])
			send_sample(DirectedSamples[i]);
		squeeze_req <= squeeze_req + 1;
		drive_signal_mix(510);

		tx_idle_pct = 54;
		rx_idle_pct = 31;
		squeeze_req <= squeeze_req + 1;
		drive_signal_mix(510);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		squeeze_req <= squeeze_req + 1;
		drive_signal_mix(510);
		s_tvalid <= 1'b0;

		for (int w = 0; w < 5000 && pending != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending != 0)
			$error("%0d filtered samples never came out", pending);

		$display("Sent %0d samples: impulses, full-scale runs, tap-matched bursts, noise,",
			beats_in);
		$display("under three stall mixes; checked %0d outputs, %0d of them at full scale.",
			beats_out, full_scale_outs);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
